[rtl/core/msg_pkg.sv]
// Shared types, sizes and helper functions for the snake sequence grid block.
// Used by the top level and the testbench; depends on nothing else.
package msg_pkg;

    // Largest grid side the storage is built for.
    localparam int MAX_SIDE = 16;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;

    // Widths that follow from the grid size.
    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int LEN_W   = $clog2(2 * MAX_SIDE - 1);
    localparam int STEP_W  = $clog2(2 * MAX_SIDE + 1);

    // Fixed field widths.
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = LEN_W + VAL_W;

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [SIDE_W-1:0]        t_side;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [STEP_W-1:0]        t_step;
    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic [CFG_W-1:0]         t_cfg;

    // Grid side after reset.
    localparam t_cfg CFG_RESET = t_cfg'(16);

    // One cell entry as held in the RAM.
    typedef struct packed {
        t_len   len;
        t_value value;
    } t_entry;

    // Load phase and the steps of the backtrack walk.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_TAIL,
        ST_TAIL_UP,
        ST_UP,
        ST_LEFT,
        ST_DECIDE
    } t_state;

    // Linear cell address, rows at a stride of MAX_SIDE.
    function automatic t_addr cell_addr(input t_coord row, input t_coord col);
        return t_addr'(ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col));
    endfunction

    // Address of the cell one row above.
    function automatic t_addr up_addr(input t_addr a);
        return t_addr'(a - ADDR_W'(MAX_SIDE));
    endfunction

    // Address of the cell one column to the left.
    function automatic t_addr left_addr(input t_addr a);
        return t_addr'(a - ADDR_W'(1));
    endfunction

    // True when the two values differ by exactly one in either direction.
    function automatic logic differ_by_one(input t_value a, input t_value b);
        logic [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return (d == {{VAL_W{1'b0}}, 1'b1}) || (d == {(VAL_W + 1){1'b1}});
    endfunction

    // Side length in use: zero counts as one, large values clamp to MAX_SIDE.
    function automatic t_side side_in_use(input t_cfg cfg);
        if (cfg == '0) begin
            return t_side'(1);
        end else if (int'(cfg) > MAX_SIDE) begin
            return t_side'(MAX_SIDE);
        end
        return t_side'(cfg);
    endfunction

endpackage

[rtl/core/max_snake_sequence_grid_top.sv]
// Top level of the maximum-length snake sequence block over a square grid.
// Depends on msg_pkg and msg_ram.
//
// Cells of an N-by-N grid enter in raster order, one item per cycle, and each
// is written to the cell RAM in the cycle after it is taken; the upper neighbor
// is read from the RAM and the left neighbor is kept in registers, so loading
// runs at a sustained one cell per cycle. After the last cell the input
// stalls while the block walks back from the tail of the longest snake to its
// head and emits one result item per path cell, tail first, with path_end set
// on the head. The walk reads the RAM through its single read port: for the tail
// cell it reads the entry, then its upper and left neighbors, and for every
// further cell its upper and left neighbors, so the input stays stalled until
// the head has been emitted, including any time the output is stalled.
// A grid_size write is taken only while the block is idle and restarts the
// grid being loaded; while it waits, the input is stalled. There is no
// clearing pass after reset.
module max_snake_sequence_grid_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  msg_pkg::t_cfg     i_cfg_data,
    // Input cell channel.
    input  logic              i_cell_valid,
    output logic              o_cell_stall,
    input  msg_pkg::t_value   i_cell_value,
    // Output path channel.
    output logic              o_path_valid,
    input  logic              i_path_stall,
    output msg_pkg::t_coord   o_path_row,
    output msg_pkg::t_coord   o_path_col,
    output msg_pkg::t_value   o_path_value,
    output msg_pkg::t_len     o_snake_length,
    output logic              o_path_end
);

    import msg_pkg::*;

    // Control state.
    t_state r_state, n_state;
    t_cfg   r_grid_size;
    t_coord r_row, r_col;
    logic   r_s1_valid;
    t_len   r_best;
    t_coord r_tail_row, r_tail_col;
    t_step  r_steps;
    logic   r_out_valid;

    // Payload registers.
    logic   r_s1_last;
    t_coord r_s1_row, r_s1_col;
    t_value r_s1_value;
    t_entry r_left;
    t_coord r_w_row, r_w_col;
    t_entry r_cur, r_up;
    t_coord r_out_row, r_out_col;
    t_value r_out_value;
    t_len   r_out_len;
    logic   r_out_end;

    // RAM connections.
    logic   ram_we;
    t_addr  ram_waddr, ram_raddr;
    t_entry ram_wdata, ram_rd;

    // Strobes from the state machine.
    logic   cap_cur, cap_up, emit, walk_start;

    msg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    // Handshakes and grid position of the incoming cell. A pending
    // configuration write holds off the input so the two never meet.
    t_side side;
    logic  in_accept, cfg_accept, col_more, row_more, in_last, out_free;

    assign side         = side_in_use(r_grid_size);
    assign o_cell_stall = (r_state != ST_LOAD) || (r_s1_valid && r_s1_last) || i_cfg_valid;
    assign in_accept    = i_cell_valid && !o_cell_stall;
    assign o_cfg_ready  = (r_state == ST_LOAD) && !r_s1_valid && !r_out_valid;
    assign cfg_accept   = i_cfg_valid && o_cfg_ready;
    assign col_more     = (t_side'(r_col) + t_side'(1)) < side;
    assign row_more     = (t_side'(r_row) + t_side'(1)) < side;
    assign in_last      = !col_more && !row_more;
    assign out_free     = !r_out_valid || !i_path_stall;

    // Length update of the cell in the second stage. The upper neighbor comes
    // from the RAM, the left neighbor from the previous cell's registers.
    logic   up_ok, left_ok, upd_a, upd_b;
    t_len   up_len, left_len, len_a, len_b, best_a;
    t_entry s2_entry;

    always_comb begin
        up_ok    = (r_s1_row != '0) && differ_by_one(ram_rd.value, r_s1_value);
        left_ok  = (r_s1_col != '0) && differ_by_one(r_left.value, r_s1_value);
        up_len   = t_len'(ram_rd.len + t_len'(1));
        left_len = t_len'(r_left.len + t_len'(1));
        len_a    = up_ok ? up_len : '0;
        upd_a    = up_ok && (up_len > r_best);
        best_a   = upd_a ? up_len : r_best;
        len_b    = (left_ok && (left_len > len_a)) ? left_len : len_a;
        upd_b    = left_ok && (len_b > best_a);
        s2_entry = '{len: len_b, value: r_s1_value};
    end

    // Predecessor choice during the walk; the left neighbor is on the RAM
    // output while deciding. Up wins a tie.
    logic up_pred, left_pred, walk_head;

    always_comb begin
        up_pred   = (r_w_row != '0)
                    && (t_len'(r_up.len + t_len'(1)) == r_cur.len)
                    && differ_by_one(r_up.value, r_cur.value);
        left_pred = (r_w_col != '0)
                    && (t_len'(ram_rd.len + t_len'(1)) == r_cur.len)
                    && differ_by_one(ram_rd.value, r_cur.value);
        walk_head = (r_cur.len == '0)
                    || (r_steps >= t_step'(2 * MAX_SIDE))
                    || !(up_pred || left_pred);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (r_s1_valid && r_s1_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL:    n_state = ST_TAIL_UP;
            ST_TAIL_UP: n_state = ST_LEFT;
            ST_UP:      n_state = ST_LEFT;
            ST_LEFT:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (out_free) begin
                    n_state = walk_head ? ST_LOAD : ST_UP;
                end
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    // RAM addressing and strobes per state.
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = cell_addr(r_s1_row, r_s1_col);
        ram_wdata  = s2_entry;
        ram_raddr  = up_addr(cell_addr(r_row, r_col));
        cap_cur    = 1'b0;
        cap_up     = 1'b0;
        emit       = 1'b0;
        walk_start = 1'b0;
        case (r_state)
            ST_LOAD: begin
                ram_we = r_s1_valid;
            end
            ST_TAIL: begin
                ram_raddr  = cell_addr(r_tail_row, r_tail_col);
                walk_start = 1'b1;
            end
            ST_TAIL_UP: begin
                ram_raddr = up_addr(cell_addr(r_w_row, r_w_col));
                cap_cur   = 1'b1;
            end
            ST_UP: begin
                ram_raddr = up_addr(cell_addr(r_w_row, r_w_col));
            end
            ST_LEFT: begin
                ram_raddr = left_addr(cell_addr(r_w_row, r_w_col));
                cap_up    = 1'b1;
            end
            ST_DECIDE: begin
                ram_raddr = left_addr(cell_addr(r_w_row, r_w_col));
                emit      = out_free;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_grid_size <= CFG_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_best      <= '0;
            r_tail_row  <= '0;
            r_tail_col  <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= in_accept;

            // A configuration write restarts the grid.
            if (cfg_accept) begin
                r_grid_size <= i_cfg_data;
                r_row       <= '0;
                r_col       <= '0;
                r_best      <= '0;
                r_tail_row  <= '0;
                r_tail_col  <= '0;
            end

            // Advance the raster position of the next cell.
            if (in_accept) begin
                if (col_more) begin
                    r_col <= t_coord'(r_col + t_coord'(1));
                end else if (row_more) begin
                    r_col <= '0;
                    r_row <= t_coord'(r_row + t_coord'(1));
                end else begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end

            // Keep the best length and the first cell that reached it.
            if (r_s1_valid) begin
                if (upd_b) begin
                    r_best <= len_b;
                end else begin
                    r_best <= best_a;
                end
                if (upd_a || upd_b) begin
                    r_tail_row <= r_s1_row;
                    r_tail_col <= r_s1_col;
                end
            end

            // Walk step count; the grid restarts after the head is emitted.
            if (walk_start) begin
                r_steps <= '0;
            end
            if (emit) begin
                if (walk_head) begin
                    r_best     <= '0;
                    r_tail_row <= '0;
                    r_tail_col <= '0;
                end else begin
                    r_steps <= t_step'(r_steps + t_step'(1));
                end
            end

            // Output register valid.
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_path_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s1_value <= i_cell_value;
            r_s1_last  <= in_last;
        end
        if (r_s1_valid) begin
            r_left <= s2_entry;
        end
        if (walk_start) begin
            r_w_row <= r_tail_row;
            r_w_col <= r_tail_col;
        end
        if (cap_cur) begin
            r_cur <= ram_rd;
        end
        if (cap_up) begin
            r_up <= ram_rd;
        end
        if (emit) begin
            r_out_row   <= r_w_row;
            r_out_col   <= r_w_col;
            r_out_value <= r_cur.value;
            r_out_len   <= r_best;
            r_out_end   <= walk_head;
            // Step to the predecessor, carrying its entry along.
            if (!walk_head) begin
                if (up_pred) begin
                    r_w_row <= t_coord'(r_w_row - t_coord'(1));
                    r_cur   <= r_up;
                end else begin
                    r_w_col <= t_coord'(r_w_col - t_coord'(1));
                    r_cur   <= ram_rd;
                end
            end
        end
    end

    assign o_path_valid   = r_out_valid;
    assign o_path_row     = r_out_row;
    assign o_path_col     = r_out_col;
    assign o_path_value   = r_out_value;
    assign o_snake_length = r_out_len;
    assign o_path_end     = r_out_end;

endmodule

[rtl/core/msg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the cell entries of the snake sequence grid block.
module msg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/tb.sv]
// Self-checking testbench for max_snake_sequence_grid_top: grids of cells go in,
// and every path item that comes out is checked against an in-bench predictor.
// Depends on msg_pkg and the RTL of the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msg_pkg::*;

    // One path item as it leaves the block.
    typedef struct packed {
        t_coord row;
        t_coord col;
        t_value value;
        t_len   len;
        logic   head;
    } t_path_item;

    // Kinds of rows in the directed table.
    typedef enum logic {
        ROW_CFG,
        ROW_CELL
    } t_row_kind;

    // Ways of filling a random grid.
    typedef enum logic [1:0] {
        FILL_NEAR,
        FILL_RAMP,
        FILL_RAMP_NOISY,
        FILL_NOISE
    } t_fill;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] data;
        logic        typed;
        t_path_item  exp;
    } t_stim_row;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned CFG_SETTLE  = 8;
    localparam int unsigned END_SETTLE  = 80;
    localparam int unsigned MAX_REPORTS = 10;
    localparam t_cfg        CFG_ALL_ONES = '1;
    localparam t_path_item  NO_EXP = '0;
    localparam int unsigned SEND_IDLE [3] = '{16, 82, 0};
    localparam int unsigned RECV_IDLE [3] = '{82, 16, 0};

    // Directed rows: reset size, one-cell grids, grids without moves, sign wrap,
    // the up/left tie, and a left step near the top of the value range.
    localparam t_stim_row DIRECTED [27] = '{
        '{ROW_CELL, 16'h0064, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0065, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0066, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0005, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0000, 1'b0, NO_EXP},
        '{ROW_CFG,  16'h0001, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFF, 1'b1, '{4'd0, 4'd0, 16'sh7FFF, 5'd0, 1'b1}},
        '{ROW_CELL, 16'h8000, 1'b1, '{4'd0, 4'd0, 16'sh8000, 5'd0, 1'b1}},
        '{ROW_CFG,  16'h0000, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0000, 1'b1, '{4'd0, 4'd0, 16'sh0000, 5'd0, 1'b1}},
        '{ROW_CFG,  16'h0002, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0007, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0009, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h000B, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h000D, 1'b1, '{4'd0, 4'd0, 16'sh0007, 5'd0, 1'b1}},
        '{ROW_CELL, 16'h8000, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFF, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFF, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h8000, 1'b1, '{4'd0, 4'd0, 16'sh8000, 5'd0, 1'b1}},
        '{ROW_CELL, 16'hFFFF, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0000, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0000, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h0001, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFE, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFC, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFF, 1'b0, NO_EXP},
        '{ROW_CELL, 16'h7FFE, 1'b0, NO_EXP}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    t_cfg    i_cfg_data = '0;
    logic    i_cell_valid = 1'b0;
    logic    o_cell_stall;
    t_value  i_cell_value = '0;
    logic    o_path_valid;
    logic    i_path_stall = 1'b0;
    t_coord  o_path_row;
    t_coord  o_path_col;
    t_value  o_path_value;
    t_len    o_snake_length;
    logic    o_path_end;

    // Predictor state: the shadow of the grid and the block's counters.
    t_value      cell_val [CELLS];
    int unsigned cell_len [CELLS];
    t_cfg        side_reg = CFG_RESET;
    int unsigned cur_row = 0;
    int unsigned cur_col = 0;
    int unsigned best_len = 0;
    int unsigned tail_idx = 0;

    t_path_item  expected_path [$];
    t_path_item  fresh_path [$];

    int unsigned cell_idle_pct = SEND_IDLE[0];
    int unsigned path_idle_pct = RECV_IDLE[0];
    int unsigned cells_sent = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          grid_open = 1'b0;

    max_snake_sequence_grid_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cell_valid   (i_cell_valid),
        .o_cell_stall   (o_cell_stall),
        .i_cell_value   (i_cell_value),
        .o_path_valid   (o_path_valid),
        .i_path_stall   (i_path_stall),
        .o_path_row     (o_path_row),
        .o_path_col     (o_path_col),
        .o_path_value   (o_path_value),
        .o_snake_length (o_snake_length),
        .o_path_end     (o_path_end)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The run ends here if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random with the current rate.
    always @(negedge i_clk) begin
        i_path_stall <= ($urandom_range(0, 99) < path_idle_pct);
    end

    function automatic int unsigned side_of(input t_cfg cfg);
        if (cfg == '0) begin
            return 1;
        end else if (int'(cfg) > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(cfg);
    endfunction

    function automatic bit adjacent(input t_value a, input t_value b);
        int d;
        d = int'(a) - int'(b);
        return (d == 1) || (d == -1);
    endfunction

    function automatic t_path_item make_entry(input int unsigned r, input int unsigned c,
                                              input logic head);
        t_path_item p;
        p.row   = t_coord'(r);
        p.col   = t_coord'(c);
        p.value = cell_val[r * MAX_SIDE + c];
        p.len   = t_len'(best_len);
        p.head  = head;
        return p;
    endfunction

    function automatic string show(input t_path_item p);
        return $sformatf("row %0d col %0d value %0d length %0d end %0d",
                         p.row, p.col, p.value, p.len, p.head);
    endfunction

    task automatic restart_grid();
        cur_row  = 0;
        cur_col  = 0;
        best_len = 0;
        tail_idx = 0;
    endtask

    // Walk from the tail back to the head, up before left, into fresh_path.
    task automatic trace_back();
        int unsigned r, c, idx, len, steps;
        r = tail_idx / MAX_SIDE;
        c = tail_idx % MAX_SIDE;
        steps = 0;
        while (cell_len[r * MAX_SIDE + c] != 0 && steps < 2 * MAX_SIDE) begin
            idx = r * MAX_SIDE + c;
            len = cell_len[idx];
            fresh_path = {fresh_path, make_entry(r, c, 1'b0)};
            if (r > 0 && cell_len[idx - MAX_SIDE] + 1 == len &&
                    adjacent(cell_val[idx - MAX_SIDE], cell_val[idx])) begin
                r = r - 1;
            end else if (c > 0 && cell_len[idx - 1] + 1 == len &&
                    adjacent(cell_val[idx - 1], cell_val[idx])) begin
                c = c - 1;
            end else begin
                // No predecessor: this cell is not a step, it becomes the head.
                void'(fresh_path.pop_back());
                break;
            end
            steps++;
        end
        fresh_path = {fresh_path, make_entry(r, c, 1'b1)};
    endtask

    // Store one cell, score its snake length and walk back after the last cell.
    task automatic score_cell(input t_value v);
        int unsigned side, idx, len, alt;
        side = side_of(side_reg);
        if (cur_row >= side || cur_col >= side) begin
            restart_grid();
        end
        idx = cur_row * MAX_SIDE + cur_col;
        cell_val[idx] = v;
        len = 0;
        if (cur_row > 0 && adjacent(cell_val[idx - MAX_SIDE], v)) begin
            len = cell_len[idx - MAX_SIDE] + 1;
            if (len > best_len) begin
                best_len = len;
                tail_idx = idx;
            end
        end
        if (cur_col > 0 && adjacent(cell_val[idx - 1], v)) begin
            alt = cell_len[idx - 1] + 1;
            if (alt > len) begin
                len = alt;
            end
            if (len > best_len) begin
                best_len = len;
                tail_idx = idx;
            end
        end
        cell_len[idx] = len;
        if (cur_col + 1 < side) begin
            cur_col = cur_col + 1;
        end else if (cur_row + 1 < side) begin
            cur_col = 0;
            cur_row = cur_row + 1;
        end else begin
            trace_back();
            restart_grid();
        end
    endtask

    // Present one cell, hold it until taken, then book its expected path items.
    task automatic send_cell(input t_value v, input bit typed, input t_path_item fixed);
        while ($urandom_range(0, 99) < cell_idle_pct) begin
            i_cell_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cell_valid <= 1'b1;
        i_cell_value <= v;
        do @(posedge i_clk); while (o_cell_stall);
        cells_sent++;
        fresh_path.delete();
        score_cell(v);
        if (typed) begin
            expected_path = {expected_path, fixed};
        end else begin
            expected_path = {expected_path, fresh_path};
        end
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected path item has come out.
    task automatic wait_quiet(input int unsigned settle);
        i_cell_valid <= 1'b0;
        while (expected_path.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_size(input t_cfg v);
        wait_quiet(CFG_SETTLE);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        side_reg  = v;
        grid_open = 1'b0;
        restart_grid();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_value cell_pattern(input t_fill kind, input t_value base,
                                            input bit down, input int unsigned r,
                                            input int unsigned c);
        int ramp;
        ramp = down ? -int'(r + c) : int'(r + c);
        case (kind)
            FILL_NEAR: begin
                return t_value'(int'(base) + int'($urandom_range(0, 3)));
            end
            FILL_RAMP: begin
                return t_value'(int'(base) + ramp);
            end
            FILL_RAMP_NOISY: begin
                if ($urandom_range(0, 7) == 0) begin
                    return t_value'($urandom);
                end
                return t_value'(int'(base) + ramp);
            end
            default: begin
                return t_value'($urandom);
            end
        endcase
    endfunction

    // One random grid, sometimes under a new size and sometimes cut short.
    task automatic random_grid();
        int unsigned pick, side, cells, total, fill_pick;
        t_fill       kind;
        t_value      base;
        bit          down, partial;
        partial = 1'b0;
        if (grid_open || $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                write_size(t_cfg'($urandom_range(0, 31)));
            end else if (pick < 3) begin
                write_size(t_cfg'($urandom_range(0, 1)));
            end else if (pick < 5) begin
                write_size(t_cfg'($urandom_range(6, 8)));
            end else begin
                write_size(t_cfg'($urandom_range(2, 5)));
            end
            partial = (pick == 0) || ($urandom_range(0, 9) == 0);
        end
        side  = side_of(side_reg);
        cells = side * side;
        total = partial ? $urandom_range(0, (cells > 12 ? 12 : cells) - 1) : cells;
        grid_open = partial;
        fill_pick = $urandom_range(0, 19);
        if (fill_pick < 8) begin
            kind = FILL_RAMP_NOISY;
        end else if (fill_pick < 16) begin
            kind = FILL_NEAR;
        end else if (fill_pick < 18) begin
            kind = FILL_RAMP;
        end else begin
            kind = FILL_NOISE;
        end
        base = t_value'($urandom);
        down = $urandom_range(0, 1);
        for (int i = 0; i < total; i++) begin
            send_cell(cell_pattern(kind, base, down, i / side, i % side), 1'b0, NO_EXP);
        end
    endtask

    // Count a mismatch and report the first few.
    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Compare each accepted path item with the oldest expectation.
    always @(posedge i_clk) begin
        t_path_item got, want;
        if (i_rst_n && o_path_valid && !i_path_stall) begin
            got = '{o_path_row, o_path_col, o_path_value, o_snake_length, o_path_end};
            if (expected_path.size() == 0) begin
                flag_mismatch({"unexpected item: ", show(got)});
            end else begin
                want = expected_path.pop_front();
                if (got !== want) begin
                    flag_mismatch({"expected ", show(want), ", got ", show(got)});
                end
            end
        end
    end

    // Reset, directed table, two random phases, then a full-size ramp grid, each phase with different idling.
    initial begin
        int unsigned mode_cells;
        t_value      base;
        bit          down;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_size(t_cfg'(DIRECTED[i].data));
            end else begin
                send_cell(t_value'(DIRECTED[i].data), DIRECTED[i].typed, DIRECTED[i].exp);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            cell_idle_pct = SEND_IDLE[mode];
            path_idle_pct = RECV_IDLE[mode];
            mode_cells    = cells_sent;
            if (mode == 2) begin
                // Full-size grid on a clean ramp: the longest possible snake.
                write_size(CFG_ALL_ONES);
                base = t_value'($urandom);
                down = $urandom_range(0, 1);
                for (int i = 0; i < CELLS; i++) begin
                    send_cell(cell_pattern(FILL_RAMP, base, down, i / MAX_SIDE, i % MAX_SIDE),
                              1'b0, NO_EXP);
                end
            end
            while (cells_sent - mode_cells < (mode == 2 ? 0 : 25)) begin
                random_grid();
            end
        end

        wait_quiet(END_SETTLE);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[max_snake_sequence_grid_top.f]
rtl/core/msg_pkg.sv
rtl/core/msg_ram.sv
rtl/core/max_snake_sequence_grid_top.sv
dv/tb.sv
